>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// concurrent assertion helpers, empty under synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_ALWAYS(name, clk, rstn, expr) \
  name: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
    else $error("assertion failed");
`define ASSERT_IMPLIES(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(name, clk, rstn, expr)
`define ASSERT_IMPLIES(name, clk, rstn, ante, cons)
`define ASSERT_NEXT(name, clk, rstn, ante, cons)
`endif
`endif

>>> design/brms_pkg.sv
// ----------------------------------------------------------------------------
// brms_pkg
// shared types and constants of the block rms unit
// ----------------------------------------------------------------------------
`default_nettype none
package brms_pkg;
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QIDX_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);
  localparam logic [16:0] MAX_BLOCK = 17'h10000;
  localparam logic [31:0] SEED_MAGIC = 32'h5f3759df;
  localparam logic [31:0] THREE_HALF = 32'h30000000;

  typedef struct packed {
    logic [62:0] sum;
    logic [16:0] count;
    logic        ovf;
  } blk_entry_t;
endpackage
`default_nettype wire

>>> design/brms_if.sv
// ----------------------------------------------------------------------------
// brms_if
// sample and result channels
// ----------------------------------------------------------------------------
`default_nettype none
interface brms_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] sample;
  logic               last;
  modport source (output valid, output sample, output last, input ready);
  modport sink (input valid, input sample, input last, output ready);
endinterface

interface brms_out_if;
  logic        valid;
  logic        ready;
  logic [30:0] rms;
  logic [16:0] sample_count;
  logic        overflow;
  modport source (output valid, output rms, output sample_count, output overflow,
                  input ready);
  modport sink (input valid, input rms, input sample_count, input overflow,
                output ready);
endinterface
`default_nettype wire

>>> design/block_rms_q31.sv
// one sample accepted per cycle while the queue has room; the square and the accumulate are each registered
// a result is offered after serial division, up to 15 normalise steps and 10 multiplier
// passes, or after division alone for a zero mean; the engine works on one block at a
// time, and a four-entry queue of finished sums lets short blocks stream on until it fills,
// then the input stalls
// asynchronous active-low reset clears the sums, counts, queue and engine state
// ----------------------------------------------------------------------------
// block_rms_q31
// streaming q31 root mean square per block
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module block_rms_q31
  import brms_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  brms_in_if.sink    in_i,
  brms_out_if.source out_o
);
  logic              push;
  logic              pop;
  blk_entry_t        push_entry;
  blk_entry_t        head_entry;
  logic [QCNT_W-1:0] q_cnt;

  brms_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .q_cnt_i (q_cnt),
    .push_o  (push),
    .entry_o (push_entry)
  );

  brms_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .entry_o (head_entry),
    .cnt_o   (q_cnt)
  );

  brms_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .q_cnt_i (q_cnt),
    .entry_i (head_entry),
    .pop_o   (pop),
    .out_o   (out_o)
  );

  `ASSERT_ALWAYS(a_q_bound, clk_i, rst_ni, q_cnt <= QCNT_W'(QDEPTH))
  `ASSERT_IMPLIES(a_no_push_full, clk_i, rst_ni, push, q_cnt < QCNT_W'(QDEPTH))
  `ASSERT_IMPLIES(a_full_stalls, clk_i, rst_ni, q_cnt == QCNT_W'(QDEPTH), !in_i.ready)
  `ASSERT_NEXT(a_pop_drains, clk_i, rst_ni, pop && !push, q_cnt == $past(q_cnt) - 1'b1)
endmodule
`default_nettype wire

>>> design/brms_front.sv
// ----------------------------------------------------------------------------
// brms_front
// squares samples and accumulates per-block sum and count
// ----------------------------------------------------------------------------
`default_nettype none
module brms_front
  import brms_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  brms_in_if.sink                in_i,
  input  wire logic [QCNT_W-1:0] q_cnt_i,
  output      logic              push_o,
  output      blk_entry_t        entry_o
);
  logic        v_q, last_q;
  logic [62:0] sq_q;
  logic [62:0] sum_q;
  logic [16:0] cnt_q;
  logic        ovf_q;
  logic [63:0] sum_add;
  logic [62:0] sum_d;
  logic [16:0] cnt_d;
  logic        ovf_d;
  logic signed [63:0] prod;
  logic [QCNT_W:0] occ;

  assign occ = {1'b0, q_cnt_i} + {{QCNT_W{1'b0}}, v_q & last_q};
  assign in_i.ready = occ < (QCNT_W+1)'(QDEPTH);
  assign prod = $signed(in_i.sample) * $signed(in_i.sample);

  always_comb begin
    sum_add = {1'b0, sum_q} + {1'b0, sq_q};
    ovf_d = ovf_q;
    if (sum_add[63]) begin
      sum_d = '1;
      ovf_d = 1'b1;
    end else begin
      sum_d = sum_add[62:0];
    end
    if (cnt_q >= MAX_BLOCK) begin
      cnt_d = MAX_BLOCK;
      ovf_d = 1'b1;
    end else begin
      cnt_d = cnt_q + 17'd1;
    end
  end

  assign push_o = v_q & last_q;
  assign entry_o = '{sum: sum_d, count: cnt_d, ovf: ovf_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
      last_q <= 1'b0;
      sum_q <= '0;
      cnt_q <= '0;
      ovf_q <= 1'b0;
    end else begin
      v_q <= in_i.valid & in_i.ready;
      if (in_i.valid && in_i.ready) begin
        last_q <= in_i.last;
      end
      if (v_q) begin
        if (last_q) begin
          sum_q <= '0;
          cnt_q <= '0;
          ovf_q <= 1'b0;
        end else begin
          sum_q <= sum_d;
          cnt_q <= cnt_d;
          ovf_q <= ovf_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      sq_q <= prod[62:0];
    end
  end
endmodule
`default_nettype wire

>>> design/brms_fifo.sv
// ----------------------------------------------------------------------------
// brms_fifo
// short queue of finished block sums
// ----------------------------------------------------------------------------
`default_nettype none
module brms_fifo
  import brms_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire blk_entry_t        entry_i,
  input  wire logic              pop_i,
  output      blk_entry_t        entry_o,
  output      logic [QCNT_W-1:0] cnt_o
);
  blk_entry_t        mem_q [QDEPTH];
  logic [QIDX_W-1:0] wp_q, rp_q;
  logic [QCNT_W-1:0] cnt_q;

  assign entry_o = mem_q[rp_q];
  assign cnt_o = cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= wp_q + 1'b1;
      if (pop_i) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + QCNT_W'(push_i) - QCNT_W'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= entry_i;
  end
endmodule
`default_nettype wire

>>> design/brms_back.sv
// ----------------------------------------------------------------------------
// brms_back
// mean by serial division, then newton square root on one multiplier
// ----------------------------------------------------------------------------
`default_nettype none
module brms_back
  import brms_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [QCNT_W-1:0] q_cnt_i,
  input  wire blk_entry_t        entry_i,
  output      logic              pop_o,
  brms_out_if.source             out_o
);
  typedef enum logic [2:0] {ST_IDLE, ST_DIV, ST_NORM, ST_SEED, ST_MUL, ST_OUT} state_e;
  typedef enum logic [1:0] {OP_SQ, OP_HALF, OP_STEP, OP_FIN} op_e;

  function automatic logic signed [31:0] seed_est(input logic [30:0] n);
    logic [23:0] m;
    logic [6:0]  rem;
    logic [6:0]  halfw;
    logic        up;
    logic [24:0] mr;
    logic [22:0] mf;
    logic [7:0]  ex;
    logic [31:0] bits;
    logic [31:0] y;
    logic [7:0]  e;
    logic [23:0] sig;
    logic signed [9:0] k;
    logic [9:0]  nk;
    logic [31:0] res;
    if (n[30]) begin
      m = n[30:7];
      rem = n[6:0];
      halfw = 7'd64;
      ex = 8'd126;
    end else begin
      m = n[29:6];
      rem = {1'b0, n[5:0]};
      halfw = 7'd32;
      ex = 8'd125;
    end
    up = (rem > halfw) || ((rem == halfw) && m[0]);
    mr = {1'b0, m} + {24'd0, up};
    if (mr[24]) begin
      mf = mr[23:1];
      ex = ex + 8'd1;
    end else begin
      mf = mr[22:0];
    end
    bits = {1'b0, ex, mf};
    y = SEED_MAGIC - {1'b0, bits[31:1]};
    e = y[30:23];
    sig = {(e != 8'd0), y[22:0]};
    if (e == 8'd0) e = 8'd1;
    k = $signed({2'b00, e}) - 10'sd120;
    nk = 10'(-k);
    if (k < 0) begin
      if (nk >= 10'd32) res = '0;
      else res = {8'd0, sig} >> nk[4:0];
    end else if (k >= 10'sd8) begin
      res = 32'h7fffffff;
    end else begin
      res = {8'd0, sig} << k[2:0];
    end
    return $signed(res);
  endfunction

  state_e             state_q;
  op_e                op_q;
  logic [1:0]         it_q;
  logic [62:0]        div_q;
  logic [17:0]        rem_q;
  logic [16:0]        dvs_q;
  logic [5:0]         dcnt_q;
  logic [16:0]        count_q;
  logic               ovf_q;
  logic [30:0]        num_q;
  logic [3:0]         dn_q;
  logic signed [31:0] var_q, t_q;
  logic               ov_q;
  logic [30:0]        rms_q;
  logic [16:0]        oc_q;
  logic               oo_q;

  logic [17:0]        rem_sh;
  logic               qbit;
  logic [17:0]        rem_n;
  logic signed [31:0] ma, mb;
  logic signed [63:0] prod;
  logic signed [31:0] r;
  logic signed [31:0] fin;
  logic signed [31:0] shr;

  assign rem_sh = {rem_q[16:0], div_q[62]};
  assign qbit = rem_sh >= {1'b0, dvs_q};
  assign rem_n = qbit ? rem_sh - {1'b0, dvs_q} : rem_sh;

  always_comb begin
    unique case (op_q)
      OP_SQ: begin
        ma = var_q;
        mb = var_q;
      end
      OP_HALF: begin
        ma = t_q;
        mb = $signed({2'b00, num_q[30:1]});
      end
      OP_STEP: begin
        ma = var_q;
        mb = $signed(THREE_HALF - t_q);
      end
      default: begin
        ma = $signed({1'b0, num_q});
        mb = var_q;
      end
    endcase
  end

  assign prod = ma * mb;
  assign r = prod[62:31];
  assign fin = {r[30:0], 1'b0};
  assign shr = fin >>> dn_q;

  assign pop_o = (state_q == ST_IDLE) && (q_cnt_i != '0);
  assign out_o.valid = ov_q;
  assign out_o.rms = rms_q;
  assign out_o.sample_count = oc_q;
  assign out_o.overflow = oo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q <= OP_SQ;
      it_q <= '0;
      dcnt_q <= '0;
      ov_q <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (q_cnt_i != '0) begin
            state_q <= ST_DIV;
            dcnt_q <= '0;
          end
        end
        ST_DIV: begin
          dcnt_q <= dcnt_q + 6'd1;
          if (dcnt_q == 6'd62) state_q <= ST_NORM;
        end
        ST_NORM: begin
          if (num_q == '0) begin
            state_q <= ST_OUT;
            ov_q <= 1'b1;
          end else if (num_q[30:29] != 2'b00) begin
            state_q <= ST_SEED;
          end
        end
        ST_SEED: begin
          state_q <= ST_MUL;
          op_q <= OP_SQ;
          it_q <= '0;
        end
        ST_MUL: begin
          unique case (op_q)
            OP_SQ: op_q <= OP_HALF;
            OP_HALF: op_q <= OP_STEP;
            OP_STEP: begin
              if (it_q == 2'd2) begin
                op_q <= OP_FIN;
              end else begin
                op_q <= OP_SQ;
                it_q <= it_q + 2'd1;
              end
            end
            default: begin
              state_q <= ST_OUT;
              ov_q <= 1'b1;
            end
          endcase
        end
        ST_OUT: begin
          if (out_o.ready) begin
            ov_q <= 1'b0;
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        div_q <= entry_i.sum;
        dvs_q <= entry_i.count;
        count_q <= entry_i.count;
        ovf_q <= entry_i.ovf;
        rem_q <= '0;
      end
      ST_DIV: begin
        rem_q <= rem_n;
        div_q <= {div_q[61:0], qbit};
        if (dcnt_q == 6'd62) begin
          num_q <= div_q[61] ? 31'h7fffffff : div_q[60:30];
          dn_q <= '0;
        end
      end
      ST_NORM: begin
        if (num_q == '0) begin
          rms_q <= '0;
          oc_q <= count_q;
          oo_q <= ovf_q;
        end else if (num_q[30:29] == 2'b00) begin
          num_q <= {num_q[28:0], 2'b00};
          dn_q <= dn_q + 4'd1;
        end
      end
      ST_SEED: var_q <= seed_est(num_q);
      ST_MUL: begin
        unique case (op_q)
          OP_SQ, OP_HALF: t_q <= r;
          OP_STEP: var_q <= {r[29:0], 2'b00};
          default: begin
            rms_q <= shr[30:0];
            oc_q <= count_q;
            oo_q <= ovf_q;
          end
        endcase
      end
      default: begin
        rms_q <= rms_q;
      end
    endcase
  end
endmodule
`default_nettype wire
